FILE: hw/rtl/rld_pkg.sv
package rld_pkg;

    localparam int LEVEL_BITS = 8;
    localparam int CHANNELS   = 3;

    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [3:0]            t_action;
    typedef logic [1:0]            t_select;

    // Channel order in every level vector: red, green, blue
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam t_select SEL_RED   = 2'd0;
    localparam t_select SEL_GREEN = 2'd1;
    localparam t_select SEL_BLUE  = 2'd2;
    localparam t_select SEL_ALL   = 2'd3;

    localparam t_action ACT_TOGGLE        = 4'd0;
    localparam t_action ACT_ON            = 4'd1;
    localparam t_action ACT_OFF           = 4'd2;
    localparam t_action ACT_BRIGHTEN_ALL  = 4'd3;
    localparam t_action ACT_DARKEN_ALL    = 4'd4;
    localparam t_action ACT_BRIGHTEN_SEL  = 4'd5;
    localparam t_action ACT_DARKEN_SEL    = 4'd6;
    localparam t_action ACT_SAVE          = 4'd7;
    localparam t_action ACT_RECALL        = 4'd8;
    localparam t_action ACT_SET_RGB       = 4'd9;
    localparam t_action ACT_NEXT_SELECT   = 4'd10;

    localparam t_level LVL_RESET      = t_level'(20);
    localparam t_level LVL_FULL       = t_level'(255);
    localparam t_level LVL_STEP_ALL   = t_level'(10);
    localparam t_level LVL_CEIL_ALL   = t_level'(244);
    localparam t_level LVL_STEP_SEL   = t_level'(15);
    localparam t_level LVL_CEIL_SEL   = t_level'(239);
    localparam t_level LVL_COARSE_MIN = t_level'(35);
    localparam t_level LVL_COARSE     = t_level'(14);
    localparam t_level LVL_FINE_LO    = t_level'(6);
    localparam t_level LVL_FINE_HI    = t_level'(36);
    localparam t_level LVL_FINE       = t_level'(5);
    localparam t_level LVL_FLOOR_SEL  = t_level'(8);

    typedef struct packed {
        t_level [CHANNELS-1:0] saved;
        t_level [CHANNELS-1:0] lvl;
        logic                  on;
        t_select               sel;
    } t_state;

    localparam t_state STATE_RESET = '{
        saved: '0,
        lvl:   {CHANNELS{LVL_RESET}},
        on:    1'b1,
        sel:   SEL_ALL
    };

    // Coarse step first, then the fine step on the reduced value
    function automatic t_level darken_all_one(input t_level v);
        t_level w;
        w = v;
        if (w > LVL_COARSE_MIN) w = w - LVL_COARSE;
        if (w > LVL_FINE_LO && w < LVL_FINE_HI) w = w - LVL_FINE;
        return w;
    endfunction

endpackage

FILE: hw/rtl/rld_next_state.sv
module rld_next_state (
    input  rld_pkg::t_state                               i_state,
    input  rld_pkg::t_action                              i_action,
    input  rld_pkg::t_level [rld_pkg::CHANNELS-1:0]       i_rgb,
    output rld_pkg::t_state                               o_state
);

    rld_pkg::t_action w_act;

    // Resolve toggle into on or off from the current flag
    always_comb begin
        if (i_action == rld_pkg::ACT_TOGGLE) begin
            w_act = i_state.on ? rld_pkg::ACT_OFF : rld_pkg::ACT_ON;
        end else begin
            w_act = i_action;
        end
    end

    always_comb begin
        o_state = i_state;
        case (w_act)
            rld_pkg::ACT_ON: begin
                o_state.lvl = {rld_pkg::CHANNELS{rld_pkg::LVL_FULL}};
                o_state.on  = 1'b1;
            end
            rld_pkg::ACT_OFF: begin
                o_state.lvl = '0;
                o_state.on  = 1'b0;
            end
            rld_pkg::ACT_BRIGHTEN_ALL: begin
                for (int c = 0; c < rld_pkg::CHANNELS; c++) begin
                    if (!i_state.on) begin
                        o_state.lvl[c] = rld_pkg::LVL_STEP_ALL;
                    end else if (i_state.lvl[c] < rld_pkg::LVL_CEIL_ALL) begin
                        o_state.lvl[c] = i_state.lvl[c] + rld_pkg::LVL_STEP_ALL;
                    end
                end
                o_state.on = 1'b1;
            end
            rld_pkg::ACT_DARKEN_ALL: begin
                if (i_state.on) begin
                    for (int c = 0; c < rld_pkg::CHANNELS; c++) begin
                        o_state.lvl[c] = rld_pkg::darken_all_one(i_state.lvl[c]);
                    end
                end
            end
            rld_pkg::ACT_BRIGHTEN_SEL: begin
                for (int c = 0; c < rld_pkg::CHANNELS; c++) begin
                    if (i_state.sel == rld_pkg::t_select'(c)) begin
                        if (!i_state.on) begin
                            o_state.lvl[c] = rld_pkg::LVL_STEP_ALL;
                        end else if (i_state.lvl[c] < rld_pkg::LVL_CEIL_SEL) begin
                            o_state.lvl[c] = i_state.lvl[c] + rld_pkg::LVL_STEP_SEL;
                        end
                    end
                end
                o_state.on = 1'b1;
            end
            rld_pkg::ACT_DARKEN_SEL: begin
                for (int c = 0; c < rld_pkg::CHANNELS; c++) begin
                    if (i_state.on && i_state.sel == rld_pkg::t_select'(c)
                        && i_state.lvl[c] > rld_pkg::LVL_FLOOR_SEL) begin
                        o_state.lvl[c] = i_state.lvl[c] - rld_pkg::LVL_FINE;
                    end
                end
            end
            rld_pkg::ACT_SAVE: begin
                if (i_state.on) o_state.saved = i_state.lvl;
            end
            rld_pkg::ACT_RECALL: begin
                o_state.lvl = i_state.saved;
                o_state.on  = 1'b1;
            end
            rld_pkg::ACT_SET_RGB: begin
                o_state.lvl = i_rgb;
                o_state.on  = 1'b1;
            end
            rld_pkg::ACT_NEXT_SELECT: begin
                // All wraps round to red through the two-bit overflow
                o_state.sel = i_state.sel + 2'd1;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

FILE: hw/rtl/rgb_lamp_dimmer_control.sv
// RGB lamp dimmer control: takes one lamp command per transaction (action code
// in s_axis tuser, red/green/blue levels for set_rgb in tdata) and returns one
// transaction with the three levels, the on flag and the channel selection as
// they stand after the command. A command is registered on entry and applied
// once the result slot is free, where the state registers double as the result
// register; one command can enter every cycle while the result side keeps
// taking, and the state update is a single combinational pass.
// After reset the levels are 20, the lamp is on, all channels are selected and
// the saved colour is black.
module rgb_lamp_dimmer_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic [3:0]  i_s_tuser,   // action[3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // red_level[7:0], green_level[15:8], blue_level[23:16],
                                     // lamp_on[24], select_now[26:25], zero pad
);

    logic                                     r_in_valid;
    rld_pkg::t_action                         r_in_action;
    rld_pkg::t_level [rld_pkg::CHANNELS-1:0]  r_in_rgb;
    logic                                     r_out_valid;
    rld_pkg::t_state                          r_state;
    rld_pkg::t_state                          n_state;
    logic                                     w_adv;
    logic                                     w_in_take;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action           <= i_s_tuser;
            r_in_rgb[rld_pkg::CH_RED]   <= i_s_tdata[7:0];
            r_in_rgb[rld_pkg::CH_GREEN] <= i_s_tdata[15:8];
            r_in_rgb[rld_pkg::CH_BLUE]  <= i_s_tdata[23:16];
        end
    end

    rld_next_state u_next (
        .i_state  (r_state),
        .i_action (r_in_action),
        .i_rgb    (r_in_rgb),
        .o_state  (n_state)
    );

    // State only moves when the result slot is free, so it is the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rld_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_state.sel, r_state.on,
                         r_state.lvl[rld_pkg::CH_BLUE],
                         r_state.lvl[rld_pkg::CH_GREEN],
                         r_state.lvl[rld_pkg::CH_RED]};

`ifndef ASSERT_OFF
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_tvalid)
        else $error("applied command gave no result");

    a_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_action == rld_pkg::ACT_OFF |=> !r_state.on && r_state.lvl == '0)
        else $error("off left the lamp lit");

    a_next_sel_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_action == rld_pkg::ACT_NEXT_SELECT
        |=> r_state.sel != $past(r_state.sel))
        else $error("selection did not advance");

    a_unused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_action > rld_pkg::ACT_NEXT_SELECT |=> r_state == $past(r_state))
        else $error("unused action changed state");

    a_state_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv && $past(i_rst_n) |=> $stable(r_state))
        else $error("state moved without a command");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int               CLK_HALF     = 5;
    localparam int               RESET_CYCLES = 4;
    localparam int               RANDOM_CMDS  = 650;
    localparam int               HOLD_CYCLES  = 300;
    localparam int               DRAIN_CYCLES = 10;
    localparam int               CYCLE_LIMIT  = 400000;
    localparam rld_pkg::t_action ACT_UNUSED   = 4'd15;

    typedef struct packed {
        rld_pkg::t_action action;
        rld_pkg::t_level  red;
        rld_pkg::t_level  green;
        rld_pkg::t_level  blue;
    } t_lamp_cmd;

    typedef struct packed {
        rld_pkg::t_level  red;
        rld_pkg::t_level  green;
        rld_pkg::t_level  blue;
        logic             on;
        rld_pkg::t_select sel;
    } t_lamp_view;

    typedef struct packed {
        rld_pkg::t_level [rld_pkg::CHANNELS-1:0] lvl;
        rld_pkg::t_level [rld_pkg::CHANNELS-1:0] saved;
        logic                                    on;
        rld_pkg::t_select                        sel;
    } t_lamp_state;

    typedef struct packed {
        t_lamp_cmd  cmd;
        logic       typed;
        t_lamp_view want;
    } t_cmd_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // red_in[7:0], green_in[15:8], blue_in[23:16]
    logic [3:0]  i_s_tuser;   // action[3:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;   // red[7:0], green[15:8], blue[23:16], on[24], select[26:25]

    t_lamp_state lamp_now;
    t_lamp_view  levels_due [$];
    t_cmd_row    cmd_table [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    int          rx_wait      = 0;
    logic        hold_off;

    rgb_lamp_dimmer_control dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Coarse cut on bright levels, then a fine cut on whatever lands in the dim band
    function automatic rld_pkg::t_level dim_level(input rld_pkg::t_level v);
        int w;
        w = int'(v);
        if (w > int'(rld_pkg::LVL_COARSE_MIN)) w -= int'(rld_pkg::LVL_COARSE);
        if (w > int'(rld_pkg::LVL_FINE_LO) && w < int'(rld_pkg::LVL_FINE_HI))
            w -= int'(rld_pkg::LVL_FINE);
        return rld_pkg::t_level'(w);
    endfunction

    function automatic t_lamp_state next_lamp(input t_lamp_state s, input t_lamp_cmd c);
        t_lamp_state      n;
        rld_pkg::t_action a;
        n = s;
        a = c.action;
        if (a == rld_pkg::ACT_TOGGLE) a = s.on ? rld_pkg::ACT_OFF : rld_pkg::ACT_ON;
        case (a)
            rld_pkg::ACT_ON: begin
                n.lvl = {rld_pkg::CHANNELS{rld_pkg::LVL_FULL}};
                n.on  = 1'b1;
            end
            rld_pkg::ACT_OFF: begin
                n.lvl = '0;
                n.on  = 1'b0;
            end
            rld_pkg::ACT_BRIGHTEN_ALL: begin
                if (s.on) begin
                    for (int ch = 0; ch < rld_pkg::CHANNELS; ch++)
                        if (n.lvl[ch] < rld_pkg::LVL_CEIL_ALL)
                            n.lvl[ch] = n.lvl[ch] + rld_pkg::LVL_STEP_ALL;
                end else begin
                    n.lvl = {rld_pkg::CHANNELS{rld_pkg::LVL_STEP_ALL}};
                    n.on  = 1'b1;
                end
            end
            rld_pkg::ACT_DARKEN_ALL: begin
                if (s.on)
                    for (int ch = 0; ch < rld_pkg::CHANNELS; ch++)
                        n.lvl[ch] = dim_level(n.lvl[ch]);
            end
            rld_pkg::ACT_BRIGHTEN_SEL: begin
                if (!s.on) begin
                    if (s.sel != rld_pkg::SEL_ALL) n.lvl[s.sel] = rld_pkg::LVL_STEP_ALL;
                    n.on = 1'b1;
                end else if (s.sel != rld_pkg::SEL_ALL
                             && n.lvl[s.sel] < rld_pkg::LVL_CEIL_SEL) begin
                    n.lvl[s.sel] = n.lvl[s.sel] + rld_pkg::LVL_STEP_SEL;
                end
            end
            rld_pkg::ACT_DARKEN_SEL: begin
                if (s.on && s.sel != rld_pkg::SEL_ALL
                    && n.lvl[s.sel] > rld_pkg::LVL_FLOOR_SEL)
                    n.lvl[s.sel] = n.lvl[s.sel] - rld_pkg::LVL_FINE;
            end
            rld_pkg::ACT_SAVE: begin
                if (s.on) n.saved = s.lvl;
            end
            rld_pkg::ACT_RECALL: begin
                n.lvl = s.saved;
                n.on  = 1'b1;
            end
            rld_pkg::ACT_SET_RGB: begin
                n.lvl[rld_pkg::CH_RED]   = c.red;
                n.lvl[rld_pkg::CH_GREEN] = c.green;
                n.lvl[rld_pkg::CH_BLUE]  = c.blue;
                n.on                     = 1'b1;
            end
            rld_pkg::ACT_NEXT_SELECT: begin
                n.sel = (s.sel == rld_pkg::SEL_ALL) ? rld_pkg::SEL_RED
                                                    : rld_pkg::t_select'(s.sel + 2'd1);
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic rld_pkg::t_level pick_level();
        rld_pkg::t_level edges [12] = '{0, 6, 7, 8, 9, 35, 36, 238, 239, 243, 244, 255};
        if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 11)];
        return rld_pkg::t_level'($urandom);
    endfunction

    function automatic t_lamp_cmd pick_cmd();
        t_lamp_cmd c;
        if ($urandom_range(0, 99) < 5) c.action = rld_pkg::t_action'($urandom_range(11, 15));
        else c.action = rld_pkg::t_action'($urandom_range(0, 10));
        c.red   = pick_level();
        c.green = pick_level();
        c.blue  = pick_level();
        return c;
    endfunction

    function automatic void add_row(input rld_pkg::t_action a, input rld_pkg::t_level r,
                                    input rld_pkg::t_level g, input rld_pkg::t_level b,
                                    input logic typed, input rld_pkg::t_level er,
                                    input rld_pkg::t_level eg, input rld_pkg::t_level eb,
                                    input logic eon, input rld_pkg::t_select esel);
        t_cmd_row row;
        row.cmd   = '{action: a, red: r, green: g, blue: b};
        row.typed = typed;
        row.want  = '{red: er, green: eg, blue: eb, on: eon, sel: esel};
        cmd_table.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one command, hold it until taken, then queue the levels it must produce
    task automatic send_cmd(input t_lamp_cmd c, input logic typed, input t_lamp_view want,
                            input bit calm);
        t_lamp_view got_view;
        int         gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.action;
        i_s_tdata  <= {c.blue, c.green, c.red};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        lamp_now = next_lamp(lamp_now, c);
        got_view = '{red: lamp_now.lvl[rld_pkg::CH_RED],
                     green: lamp_now.lvl[rld_pkg::CH_GREEN],
                     blue: lamp_now.lvl[rld_pkg::CH_BLUE],
                     on: lamp_now.on, sel: lamp_now.sel};
        levels_due.push_back(typed ? want : got_view);
        gap = pick_gap(calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, a calm stretch, and the long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait    <= rx_wait - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            rx_wait    <= pick_gap(results_seen >= 450 && results_seen < 530);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_lamp_view want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            results_seen <= results_seen + 1;
            if (levels_due.size() == 0) begin
                report_mismatch("transaction with nothing pending", 1, 0);
            end else begin
                want = levels_due.pop_front();
                if (o_m_tdata[7:0] !== want.red)
                    report_mismatch("red_level", int'(o_m_tdata[7:0]), int'(want.red));
                if (o_m_tdata[15:8] !== want.green)
                    report_mismatch("green_level", int'(o_m_tdata[15:8]), int'(want.green));
                if (o_m_tdata[23:16] !== want.blue)
                    report_mismatch("blue_level", int'(o_m_tdata[23:16]), int'(want.blue));
                if (o_m_tdata[24] !== want.on)
                    report_mismatch("lamp_on", int'(o_m_tdata[24]), int'(want.on));
                if (o_m_tdata[26:25] !== want.sel)
                    report_mismatch("select_now", int'(o_m_tdata[26:25]), int'(want.sel));
            end
        end
    end

    // Hold the result side off long enough for the block to back up into its input
    initial begin : hold_off_burst
        hold_off = 1'b0;
        wait (results_seen >= 120);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = rld_pkg::ACT_TOGGLE;
        lamp_now.lvl   = {rld_pkg::CHANNELS{rld_pkg::LVL_RESET}};
        lamp_now.saved = '0;
        lamp_now.on    = 1'b1;
        lamp_now.sel   = rld_pkg::SEL_ALL;

        add_row(ACT_UNUSED,                0,   0,   0, 1,  20,  20,  20, 1, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_RECALL,       0,   0,   0, 1,   0,   0,   0, 1, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_SET_RGB,    255,   0, 255, 1, 255,   0, 255, 1, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_BRIGHTEN_ALL, 0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_DARKEN_ALL,   0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_BRIGHTEN_SEL, 0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_DARKEN_SEL,   0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_NEXT_SELECT,  0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_SET_RGB,    238, 239,   9, 1, 238, 239,   9, 1, rld_pkg::SEL_RED);
        add_row(rld_pkg::ACT_BRIGHTEN_SEL, 0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_NEXT_SELECT,  0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_DARKEN_SEL,   0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_NEXT_SELECT,  0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_DARKEN_SEL,   0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_DARKEN_SEL,   0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_SAVE,         0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_OFF,          0,   0,   0, 1,   0,   0,   0, 0, rld_pkg::SEL_BLUE);
        add_row(rld_pkg::ACT_SAVE,         0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_DARKEN_ALL,   0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_BRIGHTEN_SEL, 0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_TOGGLE,       0,   0,   0, 1,   0,   0,   0, 0, rld_pkg::SEL_BLUE);
        add_row(rld_pkg::ACT_TOGGLE,       0,   0,   0, 1, 255, 255, 255, 1, rld_pkg::SEL_BLUE);
        add_row(rld_pkg::ACT_RECALL,       0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_NEXT_SELECT,  0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_OFF,          0,   0,   0, 1,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_BRIGHTEN_SEL, 0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_OFF,          0,   0,   0, 1,   0,   0,   0, 0, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_BRIGHTEN_ALL, 0,   0,   0, 1,  10,  10,  10, 1, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_SET_RGB,     36,  35,   7, 1,  36,  35,   7, 1, rld_pkg::SEL_ALL);
        add_row(rld_pkg::ACT_DARKEN_ALL,   0,   0,   0, 0,   0,   0,   0, 0, rld_pkg::SEL_ALL);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (cmd_table[k])
            send_cmd(cmd_table[k].cmd, cmd_table[k].typed, cmd_table[k].want, 1'b0);
        for (int k = 0; k < RANDOM_CMDS; k++)
            send_cmd(pick_cmd(), 1'b0, '0, k >= 300 && k < 380);
        i_s_tvalid <= 1'b0;

        wait (levels_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
